[src/tcq_pkg.sv]
// ---------------------------------------------------------------------------
// Ticket queue shared definitions
// Widths, operation and status codes, the stored entry layout, the controller
// states and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package tcq_pkg;

	localparam int TICKET_W  = 16;
	localparam int MINUTE_W  = 11;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int RUN_W     = 4;
	localparam int TDATA_W   = 32;
	localparam int PAYLOAD_W = TICKET_W + MINUTE_W;
	localparam int PAD_W     = TDATA_W - PAYLOAD_W;
	localparam int OUSER_W   = STATUS_W + 1;

	localparam logic [RUN_W-1:0] RUN_MAX     = 4'd15;
	localparam logic [RUN_W-1:0] NPP_DEFAULT = 4'd2;

	// Operation codes carried on the input tuser.
	localparam logic [KIND_W-1:0] KIND_ENQ_NORMAL   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ENQ_PRIORITY = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SERVE        = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SEARCH       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CANCEL       = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

	// Class codes.
	localparam logic CLASS_NORMAL   = 1'b0;
	localparam logic CLASS_PRIORITY = 1'b1;

	typedef struct packed {
		logic [MINUTE_W-1:0] minute;
		logic [TICKET_W-1:0] ticket;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SERVE_WB,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_RESP
	} state_t;

	// Commands from the controller; at most one is active in a cycle.
	typedef struct packed {
		logic capture;
		logic enq;
		logic res_empty;
		logic res_nop;
		logic serve_rd;
		logic serve_pop;
		logic scan_start;
		logic scan_rd;
		logic scan_next;
		logic scan_adv;
		logic res_found;
		logic res_miss;
		logic shift_rd;
		logic shift_wr;
		logic remove_done;
		logic out_load;
	} cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic              both_empty;
		logic              scan_end;
		logic              hit;
		logic              cls;
		logic              shift_end;
		logic              out_free;
	} stat_t;

endpackage

[src/tcq_ram.sv]
// ---------------------------------------------------------------------------
// Ticket queue entry memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tcq_ram #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  tcq_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output tcq_pkg::entry_t          rdata
);

	tcq_pkg::entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[src/tcq_datapath.sv]
// ---------------------------------------------------------------------------
// Ticket queue datapath
// Holds both circular queues with their heads and counts, the weighted turn
// state, the scan position, the pending result and the output register.
// ---------------------------------------------------------------------------
module tcq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tcq_pkg::cmd_t                          cmd,
	output tcq_pkg::stat_t                         stat,
	input  logic [tcq_pkg::TDATA_W-1:0]            in_tdata,
	input  logic [tcq_pkg::KIND_W-1:0]             in_tuser,
	input  logic                                   cfg_we,
	input  logic [tcq_pkg::RUN_W-1:0]              cfg_data,
	input  logic                                   out_tready,
	output logic                                   out_tvalid,
	output logic [tcq_pkg::TDATA_W-1:0]            out_tdata,
	output logic [tcq_pkg::OUSER_W-1:0]            out_tuser
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// Queue state.
	logic [AW-1:0] nhead_q, phead_q;
	logic [CW-1:0] ncount_q, pcount_q;
	logic          turn_q;
	logic [tcq_pkg::RUN_W-1:0] run_q, npp_q;
	logic [CW-1:0] k_q;
	logic          cls_q;

	// Captured transaction.
	logic [tcq_pkg::KIND_W-1:0]   op_q;
	logic [tcq_pkg::TICKET_W-1:0] tk_q;
	logic [tcq_pkg::MINUTE_W-1:0] mn_q;

	// Pending result and output register.
	logic [tcq_pkg::STATUS_W-1:0] res_status_q, out_status_q;
	logic [tcq_pkg::TICKET_W-1:0] res_ticket_q, out_ticket_q;
	logic [tcq_pkg::MINUTE_W-1:0] res_arrival_q, out_arrival_q;
	logic                         res_class_q, out_class_q;
	logic                         out_valid_q;

	// Memory ports.
	tcq_pkg::entry_t nrdata, prdata, rdata_sel, wdata;
	logic            we_n, we_p;
	logic [AW-1:0]   waddr, raddr;

	// Helpers.
	logic                 tgt_prio, tgt_full, pick_p;
	logic [AW-1:0]        tgt_head, cls_head;
	logic [CW-1:0]        tgt_count, cls_count, k_inc;
	logic [tcq_pkg::RUN_W-1:0] run_inc, run_pop;
	logic                 turn_pop, turn_norm;

	// Physical slot of the entry idx places behind head, with wrap.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
		input logic [CW-1:0] idx);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(idx);
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[AW-1:0];
	endfunction

	// Class selection and turn bookkeeping.
	always_comb begin
		tgt_prio  = op_q[0];
		tgt_head  = tgt_prio ? phead_q : nhead_q;
		tgt_count = tgt_prio ? pcount_q : ncount_q;
		tgt_full  = (tgt_count == DEPTH_C);
		cls_head  = cls_q ? phead_q : nhead_q;
		cls_count = cls_q ? pcount_q : ncount_q;
		k_inc     = k_q + ONE_C;
		pick_p    = (turn_q && (pcount_q != '0)) || (ncount_q == '0);
		rdata_sel = cls_q ? prdata : nrdata;
		run_inc   = (run_q != tcq_pkg::RUN_MAX) ? run_q + 4'd1 : run_q;
		turn_norm = (run_inc >= npp_q) ? 1'b1 : turn_q;
		if (!turn_norm && (ncount_q == ONE_C)) begin
			turn_norm = 1'b1;
		end
		if (cls_q) begin
			turn_pop = (ncount_q == '0);
			run_pop  = '0;
		end else begin
			turn_pop = turn_norm;
			run_pop  = run_inc;
		end
	end

	// Memory address and write selection.
	always_comb begin
		if (cmd.enq) begin
			waddr = slot(tgt_head, tgt_count);
			wdata = '{minute: mn_q, ticket: tk_q};
		end else begin
			waddr = slot(cls_head, k_q);
			wdata = rdata_sel;
		end
		we_n = (cmd.enq && !tgt_full && !tgt_prio) || (cmd.shift_wr && !cls_q);
		we_p = (cmd.enq && !tgt_full && tgt_prio) || (cmd.shift_wr && cls_q);
		if (cmd.serve_rd) begin
			raddr = pick_p ? phead_q : nhead_q;
		end else if (cmd.shift_rd) begin
			raddr = slot(cls_head, k_inc);
		end else begin
			raddr = slot(cls_head, k_q);
		end
	end

	tcq_ram #(.DEPTH(QUEUE_DEPTH)) u_normal_ram (
		.clk   (clk),
		.we    (we_n),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (nrdata)
	);

	tcq_ram #(.DEPTH(QUEUE_DEPTH)) u_priority_ram (
		.clk   (clk),
		.we    (we_p),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (prdata)
	);

	// Control registers: heads, counts, turn state, scan position, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nhead_q     <= '0;
			phead_q     <= '0;
			ncount_q    <= '0;
			pcount_q    <= '0;
			turn_q      <= 1'b1;
			run_q       <= '0;
			npp_q       <= tcq_pkg::NPP_DEFAULT;
			k_q         <= '0;
			cls_q       <= tcq_pkg::CLASS_NORMAL;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				npp_q <= cfg_data;
			end
			if (cmd.enq && !tgt_full) begin
				if (tgt_prio) begin
					pcount_q <= pcount_q + ONE_C;
				end else begin
					ncount_q <= ncount_q + ONE_C;
				end
			end
			if (cmd.serve_rd) begin
				cls_q <= pick_p;
			end
			if (cmd.serve_pop) begin
				turn_q <= turn_pop;
				run_q  <= run_pop;
				if (cls_q) begin
					phead_q  <= slot(phead_q, ONE_C);
					pcount_q <= pcount_q - ONE_C;
				end else begin
					nhead_q  <= slot(nhead_q, ONE_C);
					ncount_q <= ncount_q - ONE_C;
				end
			end
			if (cmd.scan_start) begin
				k_q   <= '0;
				cls_q <= tcq_pkg::CLASS_NORMAL;
			end
			if (cmd.scan_next) begin
				k_q   <= '0;
				cls_q <= tcq_pkg::CLASS_PRIORITY;
			end
			if (cmd.scan_adv || cmd.shift_wr) begin
				k_q <= k_inc;
			end
			if (cmd.remove_done) begin
				if (cls_q) begin
					pcount_q <= pcount_q - ONE_C;
				end else begin
					ncount_q <= ncount_q - ONE_C;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured transaction fields.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_tuser;
			tk_q <= in_tdata[tcq_pkg::TICKET_W-1:0];
			mn_q <= in_tdata[tcq_pkg::PAYLOAD_W-1:tcq_pkg::TICKET_W];
		end
	end

	// Pending result.
	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			res_status_q  <= tgt_full ? tcq_pkg::STATUS_FULL : tcq_pkg::STATUS_DONE;
			res_ticket_q  <= '0;
			res_arrival_q <= '0;
			res_class_q   <= tgt_prio;
		end else if (cmd.serve_pop) begin
			res_status_q  <= tcq_pkg::STATUS_DONE;
			res_ticket_q  <= rdata_sel.ticket;
			res_arrival_q <= rdata_sel.minute;
			res_class_q   <= cls_q;
		end else if (cmd.res_found) begin
			res_status_q  <= tcq_pkg::STATUS_DONE;
			res_ticket_q  <= tk_q;
			res_arrival_q <= rdata_sel.minute;
			res_class_q   <= cls_q;
		end else if (cmd.res_empty || cmd.res_miss || cmd.res_nop) begin
			res_status_q  <= cmd.res_empty ? tcq_pkg::STATUS_EMPTY :
				(cmd.res_miss ? tcq_pkg::STATUS_NOT_FOUND : tcq_pkg::STATUS_DONE);
			res_ticket_q  <= '0;
			res_arrival_q <= '0;
			res_class_q   <= tcq_pkg::CLASS_NORMAL;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q  <= res_status_q;
			out_ticket_q  <= res_ticket_q;
			out_arrival_q <= res_arrival_q;
			out_class_q   <= res_class_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.op         = op_q;
		stat.both_empty = (ncount_q == '0) && (pcount_q == '0);
		stat.scan_end   = (k_q >= cls_count);
		stat.hit        = (rdata_sel.ticket == tk_q);
		stat.cls        = cls_q;
		stat.shift_end  = (k_inc >= cls_count);
		stat.out_free   = !out_valid_q || out_tready;
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {{tcq_pkg::PAD_W{1'b0}}, out_arrival_q, out_ticket_q};
	assign out_tuser  = {out_class_q, out_status_q};

endmodule

[src/tcq_ctrl.sv]
// ---------------------------------------------------------------------------
// Ticket queue controller
// Sequences one operation at a time: capture, decode, the serve read, the
// search walk, the cancel compaction and the hand-off to the output register.
// ---------------------------------------------------------------------------
module tcq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_tvalid,
	output logic           in_tready,
	input  tcq_pkg::stat_t stat,
	output tcq_pkg::cmd_t  cmd
);

	tcq_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_tready = 1'b0;
		case (state_q)
			tcq_pkg::ST_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = tcq_pkg::ST_DECODE;
				end
			end
			tcq_pkg::ST_DECODE: begin
				case (stat.op)
					tcq_pkg::KIND_ENQ_NORMAL, tcq_pkg::KIND_ENQ_PRIORITY: begin
						cmd.enq = 1'b1;
						state_d = tcq_pkg::ST_RESP;
					end
					tcq_pkg::KIND_SERVE: begin
						if (stat.both_empty) begin
							cmd.res_empty = 1'b1;
							state_d       = tcq_pkg::ST_RESP;
						end else begin
							cmd.serve_rd = 1'b1;
							state_d      = tcq_pkg::ST_SERVE_WB;
						end
					end
					tcq_pkg::KIND_SEARCH, tcq_pkg::KIND_CANCEL: begin
						cmd.scan_start = 1'b1;
						state_d        = tcq_pkg::ST_SCAN_RD;
					end
					default: begin
						cmd.res_nop = 1'b1;
						state_d     = tcq_pkg::ST_RESP;
					end
				endcase
			end
			tcq_pkg::ST_SERVE_WB: begin
				cmd.serve_pop = 1'b1;
				state_d       = tcq_pkg::ST_RESP;
			end
			tcq_pkg::ST_SCAN_RD: begin
				if (!stat.scan_end) begin
					cmd.scan_rd = 1'b1;
					state_d     = tcq_pkg::ST_SCAN_CMP;
				end else if (stat.cls == tcq_pkg::CLASS_NORMAL) begin
					cmd.scan_next = 1'b1;
				end else begin
					cmd.res_miss = 1'b1;
					state_d      = tcq_pkg::ST_RESP;
				end
			end
			tcq_pkg::ST_SCAN_CMP: begin
				if (stat.hit) begin
					cmd.res_found = 1'b1;
					state_d = (stat.op == tcq_pkg::KIND_CANCEL) ? tcq_pkg::ST_SHIFT_RD
						: tcq_pkg::ST_RESP;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = tcq_pkg::ST_SCAN_RD;
				end
			end
			tcq_pkg::ST_SHIFT_RD: begin
				if (stat.shift_end) begin
					cmd.remove_done = 1'b1;
					state_d         = tcq_pkg::ST_RESP;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = tcq_pkg::ST_SHIFT_WR;
				end
			end
			tcq_pkg::ST_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = tcq_pkg::ST_SHIFT_RD;
			end
			tcq_pkg::ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = tcq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[src/two_class_ticket_queue_weighted_server.sv]
// ---------------------------------------------------------------------------
// Two-class ticket queue with weighted turn server
// Normal and priority circular queues of tickets with enqueue, serve, search
// and cancel operations; one result transaction per input transaction.
//
// Channel   Direction  Handshake                     Content
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: kind; tdata: ticket, minute
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: status, class; tdata: ticket, minute
// cfg       in         cfg_we (no wait)              normal tickets per priority turn
//
// Serve reads and pops the head of the chosen queue unless both are empty;
// search reads and compares each entry of the normal queue, then of the
// priority one; cancel then moves each later entry up with a read and a
// write. The single memory read port of each queue paces the walk. A new
// transaction is accepted once the previous result sits in the output
// register; a stalled output only holds the following result in its last
// step. Reset empties both queues and needs no clearing pass.
// ---------------------------------------------------------------------------
module two_class_ticket_queue_weighted_server #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] ticket, [26:16] arrival_minute, [31:27] zero
	input  logic [tcq_pkg::TDATA_W-1:0]       s_axis_tdata,
	// [2:0] kind
	input  logic [tcq_pkg::KIND_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [15:0] ticket_out, [26:16] arrival_out, [31:27] zero
	output logic [tcq_pkg::TDATA_W-1:0]       m_axis_tdata,
	// [1:0] status, [2] which_class
	output logic [tcq_pkg::OUSER_W-1:0]       m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [tcq_pkg::RUN_W-1:0]         cfg_data
);

	tcq_pkg::cmd_t  cmd;
	tcq_pkg::stat_t stat;

	tcq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

`ifndef ASSERT_OFF
	// The controller never issues two commands in one cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command active");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten");

	// In the cycle after an input transaction is accepted, the block does not accept another.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an operation is in progress");

	// A result transaction follows a load into the output register.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_axis_tvalid)
		else $error("loaded result not presented");
`endif

endmodule

[tb/two_class_ticket_queue_weighted_server_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Two-class ticket queue testbench
// Drives enqueue, serve, search and cancel transactions into the queue and
// checks every result against a behavioral copy of both queues and of the
// weighted turn rule, or fixed rows against a hand-picked table that comes
// first. Random phases follow, each with an operation mix, ticket pool and
// turn weight, and random gaps and stalls on both streams unless calm.
// ---------------------------------------------------------------------------
module two_class_ticket_queue_weighted_server_tb;

	import tcq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int PHASES     = 10;
	localparam int PHASE_OPS  = 130;
	localparam int POOL_SIZE  = 12;
	localparam int DRAIN_WAIT = 100;

	// Kind codes that the block does not use.
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

	// Operation mixes of the random phases.
	localparam int MIX_FILL   = 0;
	localparam int MIX_DRAIN  = 1;
	localparam int MIX_EVEN   = 2;
	localparam int MIX_NORMAL = 3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TICKET_W-1:0] ticket;
		logic [MINUTE_W-1:0] minute;
		logic                cls;
	} reply_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TICKET_W-1:0] ticket;
		logic [MINUTE_W-1:0] minute;
		logic                fixed;
		reply_t              want;
	} op_row_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [KIND_W-1:0]   s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [OUSER_W-1:0]  m_axis_tuser;
	logic                cfg_we        = 1'b0;
	logic [RUN_W-1:0]    cfg_data      = '0;

	// Shadow state of both queues and of the turn rule.
	logic [TICKET_W-1:0] slot_ticket [2][DEPTH];
	logic [MINUTE_W-1:0] slot_minute [2][DEPTH];
	int                  line_head [2] = '{0, 0};
	int                  line_count [2] = '{0, 0};
	logic                prio_turn = 1'b1;
	logic [RUN_W-1:0]    normal_run = '0;
	logic [RUN_W-1:0]    normals_per_turn = NPP_DEFAULT;

	reply_t              replies_due [$];
	op_row_t             directed_ops [$];
	logic [TICKET_W-1:0] ticket_pool [POOL_SIZE];
	reply_t              got_reply;
	reply_t              want_reply;
	int                  fail_count = 0;
	int                  stall_left = 0;
	logic                calm = 1'b0;

	two_class_ticket_queue_weighted_server #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one operation to the shadow queues and returns its result.
	function automatic reply_t predict_reply(input logic [KIND_W-1:0] kind,
		input logic [TICKET_W-1:0] tk, input logic [MINUTE_W-1:0] mn);
		reply_t r;
		logic   cl;
		logic   found;
		int     s;
		int     c;
		int     k;
		int     hit_c;
		int     hit_k;
		r = '0;
		r.status = STATUS_DONE;
		r.cls = CLASS_NORMAL;
		case (kind)
			KIND_ENQ_NORMAL, KIND_ENQ_PRIORITY: begin
				cl = (kind == KIND_ENQ_PRIORITY) ? CLASS_PRIORITY : CLASS_NORMAL;
				r.cls = cl;
				if (line_count[cl] >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					s = (line_head[cl] + line_count[cl]) % DEPTH;
					slot_ticket[cl][s] = tk;
					slot_minute[cl][s] = mn;
					line_count[cl]++;
				end
			end
			KIND_SERVE: begin
				if (line_count[CLASS_NORMAL] == 0 && line_count[CLASS_PRIORITY] == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					// Priority goes when it holds the turn, or when normal is empty.
					if ((prio_turn && line_count[CLASS_PRIORITY] > 0)
							|| line_count[CLASS_NORMAL] == 0) begin
						cl = CLASS_PRIORITY;
						prio_turn = 1'b0;
						normal_run = '0;
					end else begin
						cl = CLASS_NORMAL;
						if (normal_run < RUN_MAX)
							normal_run++;
						if (normal_run >= normals_per_turn)
							prio_turn = 1'b1;
					end
					s = line_head[cl];
					r.ticket = slot_ticket[cl][s];
					r.minute = slot_minute[cl][s];
					r.cls = cl;
					line_head[cl] = (s + 1) % DEPTH;
					line_count[cl]--;
					if (!prio_turn && line_count[CLASS_NORMAL] == 0)
						prio_turn = 1'b1;
				end
			end
			KIND_SEARCH, KIND_CANCEL: begin
				// Normal queue is searched first, each queue from its head.
				found = 1'b0;
				hit_c = 0;
				hit_k = 0;
				for (c = 0; c < 2 && !found; c++) begin
					for (k = 0; k < line_count[c] && !found; k++) begin
						if (slot_ticket[c][(line_head[c] + k) % DEPTH] == tk) begin
							found = 1'b1;
							hit_c = c;
							hit_k = k;
						end
					end
				end
				if (!found) begin
					r.status = STATUS_NOT_FOUND;
				end else begin
					r.ticket = tk;
					r.minute = slot_minute[hit_c][(line_head[hit_c] + hit_k) % DEPTH];
					r.cls = (hit_c == 1) ? CLASS_PRIORITY : CLASS_NORMAL;
					if (kind == KIND_CANCEL) begin
						// Close the gap and keep the order of the rest.
						for (k = hit_k; k + 1 < line_count[hit_c]; k++) begin
							s = (line_head[hit_c] + k) % DEPTH;
							c = (line_head[hit_c] + k + 1) % DEPTH;
							slot_ticket[hit_c][s] = slot_ticket[hit_c][c];
							slot_minute[hit_c][s] = slot_minute[hit_c][c];
						end
						line_count[hit_c]--;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic op_row_t directed_row(input logic [KIND_W-1:0] kind,
		input logic [TICKET_W-1:0] tk, input logic [MINUTE_W-1:0] mn,
		input logic fixed, input logic [STATUS_W-1:0] st,
		input logic [TICKET_W-1:0] want_tk, input logic [MINUTE_W-1:0] want_mn,
		input logic want_cls);
		op_row_t row;
		row.kind = kind;
		row.ticket = tk;
		row.minute = mn;
		row.fixed = fixed;
		row.want.status = st;
		row.want.ticket = want_tk;
		row.want.minute = want_mn;
		row.want.cls = want_cls;
		return row;
	endfunction

	// Gap lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(input int mix);
		int r;
		int t_en;
		int t_ep;
		int t_sv;
		int t_sr;
		int t_cn;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				t_en = 35; t_ep = 70; t_sv = 80; t_sr = 88; t_cn = 96;
			end
			MIX_DRAIN: begin
				t_en = 15; t_ep = 30; t_sv = 80; t_sr = 88; t_cn = 96;
			end
			MIX_EVEN: begin
				t_en = 22; t_ep = 44; t_sv = 74; t_sr = 86; t_cn = 98;
			end
			default: begin
				t_en = 45; t_ep = 48; t_sv = 88; t_sr = 93; t_cn = 98;
			end
		endcase
		if (r < t_en)
			return KIND_ENQ_NORMAL;
		else if (r < t_ep)
			return KIND_ENQ_PRIORITY;
		else if (r < t_sv)
			return KIND_SERVE;
		else if (r < t_sr)
			return KIND_SEARCH;
		else if (r < t_cn)
			return KIND_CANCEL;
		case ($urandom_range(0, 2))
			0: return KIND_SPARE_A;
			1: return KIND_SPARE_B;
			default: return KIND_SPARE_C;
		endcase
	endfunction

	// Tickets mostly come from a small pool so that searches and cancels hit.
	function automatic logic [TICKET_W-1:0] pick_ticket();
		if ($urandom_range(0, 99) < 85)
			return ticket_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			return TICKET_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [MINUTE_W-1:0] pick_minute();
		if ($urandom_range(0, 99) < 85)
			return MINUTE_W'($urandom_range(0, 1439));
		else
			return MINUTE_W'($urandom_range(1440, 2047));
	endfunction

	// Presents one transaction and records its expected result on accept.
	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [TICKET_W-1:0] tk,
		input logic [MINUTE_W-1:0] mn, input logic fixed, input reply_t want);
		int     gap;
		reply_t r;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {{PAD_W{1'b0}}, mn, tk};
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = predict_reply(kind, tk, mn);
		replies_due.push_back(fixed ? want : r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, none while the phase is calm.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 20)
				stall_left <= pick_stall();
		end
	end

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_reply.status = m_axis_tuser[STATUS_W-1:0];
			got_reply.cls = m_axis_tuser[STATUS_W];
			got_reply.ticket = m_axis_tdata[TICKET_W-1:0];
			got_reply.minute = m_axis_tdata[TICKET_W +: MINUTE_W];
			if (replies_due.size() == 0) begin
				$error("result with nothing expected: tuser %0h tdata %0h",
					m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				want_reply = replies_due.pop_front();
				if (got_reply.status !== want_reply.status) begin
					$error("status: expected %0d, got %0d",
						want_reply.status, got_reply.status);
					fail_count++;
				end
				if (got_reply.ticket !== want_reply.ticket) begin
					$error("ticket_out: expected %0h, got %0h",
						want_reply.ticket, got_reply.ticket);
					fail_count++;
				end
				if (got_reply.minute !== want_reply.minute) begin
					$error("arrival_out: expected %0d, got %0d",
						want_reply.minute, got_reply.minute);
					fail_count++;
				end
				if (got_reply.cls !== want_reply.cls) begin
					$error("which_class: expected %0d, got %0d",
						want_reply.cls, got_reply.cls);
					fail_count++;
				end
			end
		end
	end

	// Stimulus: directed table, then random phases with turn weight changes.
	initial begin
		int               phase;
		int               n;
		logic [RUN_W-1:0] npp_next;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty queues, unused kinds, field extremes, then a short exchange.
		directed_ops.push_back(directed_row(KIND_SERVE, 16'h0000, 11'd0, 1'b1,
			STATUS_EMPTY, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SEARCH, 16'hFFFF, 11'd0, 1'b1,
			STATUS_NOT_FOUND, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_CANCEL, 16'h0000, 11'd2047, 1'b1,
			STATUS_NOT_FOUND, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SPARE_A, 16'hFFFF, 11'd2047, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SPARE_B, 16'h0000, 11'd0, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SPARE_C, 16'h8001, 11'h555, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_ENQ_NORMAL, 16'hFFFF, 11'd2047, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_ENQ_NORMAL, 16'h0000, 11'd0, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_ENQ_PRIORITY, 16'h1234, 11'd1439, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_PRIORITY));
		directed_ops.push_back(directed_row(KIND_SEARCH, 16'h1234, 11'd0, 1'b1,
			STATUS_DONE, 16'h1234, 11'd1439, CLASS_PRIORITY));
		directed_ops.push_back(directed_row(KIND_SEARCH, 16'h0000, 11'd77, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SERVE, 16'h0000, 11'd0, 1'b1,
			STATUS_DONE, 16'h1234, 11'd1439, CLASS_PRIORITY));
		directed_ops.push_back(directed_row(KIND_SERVE, 16'h0000, 11'd0, 1'b1,
			STATUS_DONE, 16'hFFFF, 11'd2047, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_ENQ_PRIORITY, 16'hAAAA, 11'd100, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_PRIORITY));
		directed_ops.push_back(directed_row(KIND_ENQ_NORMAL, 16'h5555, 11'd200, 1'b1,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_ENQ_NORMAL, 16'hAAAA, 11'd300, 1'b0,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SEARCH, 16'hAAAA, 11'd0, 1'b0,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_CANCEL, 16'h5555, 11'd0, 1'b1,
			STATUS_DONE, 16'h5555, 11'd200, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_CANCEL, 16'hAAAA, 11'd0, 1'b0,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		directed_ops.push_back(directed_row(KIND_SEARCH, 16'hAAAA, 11'd0, 1'b0,
			STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));
		for (n = 0; n < 4; n++)
			directed_ops.push_back(directed_row(KIND_SERVE, 16'h0000, 11'd0, 1'b0,
				STATUS_DONE, 16'h0000, 11'd0, CLASS_NORMAL));

		foreach (directed_ops[i])
			send_op(directed_ops[i].kind, directed_ops[i].ticket, directed_ops[i].minute,
				directed_ops[i].fixed, directed_ops[i].want);

		for (phase = 0; phase < PHASES; phase++) begin
			// New turn weight once all results are in: one, the largest, zero, then random.
			if (phase > 0) begin
				wait_drained();
				case (phase)
					1: npp_next = 4'd1;
					2: npp_next = 4'd15;
					3: npp_next = 4'd0;
					default: npp_next = RUN_W'($urandom_range(0, 15));
				endcase
				@(negedge clk);
				cfg_we <= 1'b1;
				cfg_data <= npp_next;
				normals_per_turn = npp_next;
				@(negedge clk);
				cfg_we <= 1'b0;
			end
			calm = (phase % 4 == 3);
			for (n = 0; n < POOL_SIZE; n++)
				ticket_pool[n] = TICKET_W'($urandom_range(0, 65535));
			for (n = 0; n < PHASE_OPS; n++)
				send_op(pick_kind(phase % 4), pick_ticket(), pick_minute(), 1'b0, '0);
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && replies_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Run limit, several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
